// ===== rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the paging frame allocator: opcodes, status
// codes, sequencer states, request and response words, table commands.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Frame table sizing.
    localparam int NUM_FRAMES_DEF = 32;
    localparam int MAX_FRAMES     = 32;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int PID_W    = 8;
    localparam int MEM_W    = 22;
    localparam int PS_W     = 16;
    localparam int PAGE_W   = 5;
    localparam int FRAME_W  = 5;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE     = 1'b1;

    // Register reset values.
    localparam logic [COUNT_W-1:0] FRAMES_IN_USE_RST = 6'd32;
    localparam logic [PS_W-1:0]    PAGE_SIZE_RST     = 16'd4096;

    // Divider iteration counter, one quotient bit per cycle.
    localparam int DIV_CNT_W = $clog2(MEM_W + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE      = 2'd1,
        OP_LIST_PROC = 2'd2,
        OP_LIST_FREE = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FRAMES = 2'd1,
        ST_DONE      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_COUNT,
        S_EMIT,
        S_REPORT
    } seq_state_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [PID_W-1:0]    process_id;
        logic [MEM_W-1:0]    mem_bytes;
    } req_word_t;

    typedef struct packed {
        logic [PAGE_W-1:0]   page_index;
        logic [FRAME_W-1:0]  frame_index;
        logic [COUNT_W-1:0]  frame_count;
        status_t             status;
        logic                last;
    } rsp_word_t;

    // Command from the sequencer to the frame table.
    typedef struct packed {
        logic match_free;  // hit on a free frame instead of an owned one
        logic set_used;    // claim the frame for the current process
        logic clr_used;    // release the frame
    } tbl_cmd_t;

endpackage

// ===== rtl/pfa_divider.sv =====
// ----------------------------------------------------------------------------
// pfa_divider
// Restoring serial divider: one quotient bit per cycle, gives the quotient
// and whether the remainder is nonzero.
// ----------------------------------------------------------------------------
module pfa_divider
    import pfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MEM_W-1:0] dividend,
    input  logic [PS_W-1:0]  divisor,
    output logic             busy,
    output logic [MEM_W-1:0] quotient,
    output logic             rem_nz
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(MEM_W - 1);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MEM_W-1:0]     quo_reg, quo_next;
    logic [PS_W-1:0]      rem_reg, rem_next;
    logic [PS_W-1:0]      div_reg, div_next;
    logic [PS_W:0]        shifted;
    logic                 ge;

    // One shift, compare and subtract step.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[MEM_W-1]};
        ge        = shifted >= {1'b0, div_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? PS_W'(shifted - {1'b0, div_reg}) : PS_W'(shifted);
            quo_next = {quo_reg[MEM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign rem_nz   = rem_reg != '0;

endmodule

// ===== rtl/pfa_table.sv =====
// ----------------------------------------------------------------------------
// pfa_table
// Frame table: a used bit and an owner id per frame, with one scan port that
// tests an entry against the current request and updates it.
// ----------------------------------------------------------------------------
module pfa_table
    import pfa_pkg::*;
#(
    parameter  int DEPTH = MAX_FRAMES,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  logic [PID_W-1:0] pid,
    input  tbl_cmd_t         cmd,
    output logic             hit
);

    logic [DEPTH-1:0] used_reg;
    logic [PID_W-1:0] owner_reg [DEPTH];

    // A frame matches when it is free, or when it is held by this process.
    always_comb
    begin
        if (cmd.match_free)
        begin
            hit = !used_reg[idx];
        end
        else
        begin
            hit = used_reg[idx] && (owner_reg[idx] == pid);
        end
    end

    // Used bits clear at reset; every frame starts free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.set_used)
        begin
            used_reg[idx] <= 1'b1;
        end
        else if (cmd.clr_used)
        begin
            used_reg[idx] <= 1'b0;
        end
    end

    // The owner is only looked at while the used bit is set.
    always_ff @(posedge clk)
    begin
        if (cmd.set_used)
        begin
            owner_reg[idx] <= pid;
        end
    end

endmodule

// ===== rtl/paging_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// paging_frame_allocator
// Physical frame allocator, lowest free frame first, with a serial page
// count divider and a one-frame-per-cycle table scan.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle and is handled one frame
// per cycle. With n active frames (frames_in_use, capped at the table size)
// an allocate starts the page count divider in the accept cycle and waits
// for its result, then counts free frames over the n entries, then hands
// out frames, one response word per page. Free and list requests skip the
// divider and go straight to the counting pass, and a list then hands out
// one word per frame found. A request that ends in a single word posts it
// from the report state.
// The table scan runs one entry a cycle through a single compare port; the
// output pass pauses on a hit while the output register holds a word not
// yet taken.
// ----------------------------------------------------------------------------
module paging_frame_allocator
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_word_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_word_t             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = (NUM_FRAMES < MAX_FRAMES) ? NUM_FRAMES : MAX_FRAMES;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

    // Configuration registers.
    logic [COUNT_W-1:0] frames_reg;
    logic [PS_W-1:0]    page_size_reg;

    // Sequencer state.
    seq_state_t         state_reg, state_next;
    opcode_t            op_reg, op_next;
    logic [PID_W-1:0]   pid_reg, pid_next;
    logic [COUNT_W-1:0] scan_reg, scan_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    status_t            rep_status_reg, rep_status_next;
    logic [COUNT_W-1:0] rep_count_reg, rep_count_next;

    // Output register.
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_word_t          rsp_reg, rsp_next;

    logic               load;
    logic               slot_free;
    logic [COUNT_W-1:0] n_active;
    logic               scan_more;
    logic               hit;
    tbl_cmd_t           tbl_cmd;
    logic               div_start;
    logic [PS_W-1:0]    divisor;
    logic               div_busy;
    logic [MEM_W-1:0]   div_quo;
    logic               div_rem_nz;
    logic [MEM_W-1:0]   pages;
    logic               emit_last;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= FRAMES_IN_USE_RST;
            page_size_reg <= PAGE_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAMES_IN_USE: frames_reg    <= cfg_data[COUNT_W-1:0];
                CFG_PAGE_SIZE:     page_size_reg <= cfg_data[PS_W-1:0];
                default:           frames_reg    <= frames_reg;
            endcase
        end
    end

    assign n_active  = (frames_reg > DEPTH_CNT) ? DEPTH_CNT : frames_reg;
    assign scan_more = scan_reg < n_active;
    assign divisor   = (page_size_reg == '0) ? PS_W'(1) : page_size_reg;
    assign pages     = div_quo + MEM_W'(div_rem_nz);
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign emit_last = (k_reg + 1'b1) == total_reg;

    // Page count divider.
    pfa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.mem_bytes),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz)
    );

    // Frame table with its scan port.
    pfa_table #(
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (scan_reg[IDX_W-1:0]),
        .pid   (pid_reg),
        .cmd   (tbl_cmd),
        .hit   (hit)
    );

    // Sequencer: next state, table commands and response words.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pid_next        = pid_reg;
        scan_next       = scan_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        total_next      = total_reg;
        rep_status_next = rep_status_reg;
        rep_count_next  = rep_count_reg;
        load            = 1'b0;
        rsp_next        = rsp_reg;
        div_start       = 1'b0;
        tbl_cmd.match_free = (op_reg == OP_ALLOC) || (op_reg == OP_LIST_FREE);
        tbl_cmd.set_used   = 1'b0;
        tbl_cmd.clr_used   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next   = req.opcode;
                    pid_next  = req.process_id;
                    scan_next = '0;
                    cnt_next  = '0;
                    k_next    = '0;
                    if (req.opcode == OP_ALLOC)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_COUNT;
                    end
                end
            end

            S_DIV:
            begin
                if (!div_busy)
                begin
                    if (pages == '0)
                    begin
                        rep_status_next = ST_DONE;
                        rep_count_next  = '0;
                        state_next      = S_REPORT;
                    end
                    else
                    begin
                        state_next = S_COUNT;
                    end
                end
            end

            S_COUNT:
            begin
                if (scan_more)
                begin
                    if (hit)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        tbl_cmd.clr_used = (op_reg == OP_FREE);
                    end
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    scan_next = '0;
                    case (op_reg)
                        OP_ALLOC:
                        begin
                            if ({{(MEM_W-COUNT_W){1'b0}}, cnt_reg} < pages)
                            begin
                                rep_status_next = ST_NO_FRAMES;
                                rep_count_next  = '0;
                                state_next      = S_REPORT;
                            end
                            else
                            begin
                                total_next = pages[COUNT_W-1:0];
                                state_next = S_EMIT;
                            end
                        end
                        OP_FREE:
                        begin
                            rep_status_next = ST_DONE;
                            rep_count_next  = cnt_reg;
                            state_next      = S_REPORT;
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rep_status_next = ST_DONE;
                                rep_count_next  = '0;
                                state_next      = S_REPORT;
                            end
                            else
                            begin
                                total_next = cnt_reg;
                                state_next = S_EMIT;
                            end
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                if (hit)
                begin
                    if (slot_free)
                    begin
                        load                 = 1'b1;
                        rsp_next.page_index  = k_reg[PAGE_W-1:0];
                        rsp_next.frame_index = scan_reg[FRAME_W-1:0];
                        rsp_next.frame_count = total_reg;
                        rsp_next.status      = ST_OK;
                        rsp_next.last        = emit_last;
                        tbl_cmd.set_used     = (op_reg == OP_ALLOC);
                        k_next               = k_reg + 1'b1;
                        scan_next            = scan_reg + 1'b1;
                        if (emit_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_REPORT:
            begin
                if (slot_free)
                begin
                    load                 = 1'b1;
                    rsp_next.page_index  = '0;
                    rsp_next.frame_index = '0;
                    rsp_next.frame_count = rep_count_reg;
                    rsp_next.status      = rep_status_reg;
                    rsp_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word is held until the consumer takes it.
    always_comb
    begin
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request and response payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pid_reg        <= pid_next;
        rep_status_reg <= rep_status_next;
        rep_count_reg  <= rep_count_next;
        rsp_reg        <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A word without a frame always closes its request.
    a_nofarme_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> rsp.last)
        else $error("response without frame is not marked last");

    // A word without a frame carries no page or frame number.
    a_noframe_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |->
            (rsp.page_index == '0) && (rsp.frame_index == '0))
        else $error("response without frame carries page or frame index");

    // The output pass never runs past its word count or past the active frames.
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (k_reg < total_reg) && scan_more)
        else $error("output pass ran past its frame count");

    // The divider is only running while the sequencer waits on it.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider busy outside the divide step");

endmodule

// ===== verif/frame_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_table_checker
// Watches the request, response and configuration ports of the frame
// allocator. It keeps its own copy of the frame table and registers, works
// out the response words of every accepted request and compares each
// accepted response word, field by field, with the oldest expected word.
// ----------------------------------------------------------------------------
module frame_table_checker
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  req_word_t             req,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  rsp_word_t             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending_words
);

    // Shadow frame table and registers.
    logic              frame_busy [MAX_FRAMES];
    logic [PID_W-1:0]  frame_pid  [MAX_FRAMES];
    logic [COUNT_W-1:0] cfg_frames;
    logic [PS_W-1:0]   cfg_page_size;

    // Response words still owed by the block, oldest first.
    rsp_word_t expected_words [$];

    task automatic push_word(input int unsigned page, input int unsigned frame,
                             input int unsigned count, input status_t status,
                             input logic last);
        rsp_word_t w;
        w.page_index  = PAGE_W'(page);
        w.frame_index = FRAME_W'(frame);
        w.frame_count = COUNT_W'(count);
        w.status      = status;
        w.last        = last;
        expected_words.push_back(w);
    endtask

    // Apply one request to the shadow table and queue the words it yields.
    task automatic allocate_or_report(input req_word_t r);
        int unsigned span;
        int unsigned unit;
        int unsigned pages;
        int unsigned hits;
        int unsigned k;
        logic        hit;
        span = (cfg_frames > NUM_FRAMES) ? NUM_FRAMES : cfg_frames;
        if (span > MAX_FRAMES)
            span = MAX_FRAMES;
        hits = 0;
        k    = 0;
        case (r.opcode)
            OP_ALLOC:
            begin
                // A zero page size counts as one byte per page.
                unit  = (cfg_page_size == 0) ? 1 : cfg_page_size;
                pages = (r.mem_bytes + unit - 1) / unit;
                for (int i = 0; i < span; i++)
                    if (!frame_busy[i])
                        hits++;
                if (pages == 0)
                    push_word(0, 0, 0, ST_DONE, 1'b1);
                else if (hits < pages)
                    push_word(0, 0, 0, ST_NO_FRAMES, 1'b1);
                else
                begin
                    // Lowest free frames first, one word per page.
                    for (int i = 0; i < span && k < pages; i++)
                    begin
                        if (!frame_busy[i])
                        begin
                            frame_busy[i] = 1'b1;
                            frame_pid[i]  = r.process_id;
                            push_word(k, i, pages, ST_OK, (k + 1 == pages));
                            k++;
                        end
                    end
                end
            end
            OP_FREE:
            begin
                for (int i = 0; i < span; i++)
                begin
                    if (frame_busy[i] && frame_pid[i] == r.process_id)
                    begin
                        frame_busy[i] = 1'b0;
                        frame_pid[i]  = '0;
                        hits++;
                    end
                end
                push_word(0, 0, hits, ST_DONE, 1'b1);
            end
            default:
            begin
                // Both list requests: count first, then one word per hit.
                for (int pass = 0; pass < 2; pass++)
                begin
                    for (int i = 0; i < span; i++)
                    begin
                        hit = (r.opcode == OP_LIST_PROC)
                            ? (frame_busy[i] && frame_pid[i] == r.process_id)
                            : !frame_busy[i];
                        if (hit && pass == 0)
                            hits++;
                        else if (hit)
                        begin
                            push_word(k, i, hits, ST_OK, (k + 1 == hits));
                            k++;
                        end
                    end
                end
                if (hits == 0)
                    push_word(0, 0, 0, ST_DONE, 1'b1);
            end
        endcase
    endtask

    // Register writes, response comparison and request prediction.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                frame_busy[i] = 1'b0;
                frame_pid[i]  = '0;
            end
            cfg_frames    = FRAMES_IN_USE_RST;
            cfg_page_size = PAGE_SIZE_RST;
            expected_words.delete();
            fail_count    = 0;
            pending_words = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FRAMES_IN_USE)
                    cfg_frames = cfg_data[COUNT_W-1:0];
                else
                    cfg_page_size = cfg_data[PS_W-1:0];
            end

            // A response word belongs to an older request, so check it first.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected response word %h", rsp);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp.page_index !== want.page_index)
                    begin
                        $error("page_index: expected %0d, got %0d",
                               want.page_index, rsp.page_index);
                        fail_count++;
                    end
                    if (rsp.frame_index !== want.frame_index)
                    begin
                        $error("frame_index: expected %0d, got %0d",
                               want.frame_index, rsp.frame_index);
                        fail_count++;
                    end
                    if (rsp.frame_count !== want.frame_count)
                    begin
                        $error("frame_count: expected %0d, got %0d",
                               want.frame_count, rsp.frame_count);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, rsp.last);
                        fail_count++;
                    end
                end
            end

            if (req_valid && req_ready)
                allocate_or_report(req);

            pending_words = expected_words.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the paging frame allocator. A directed run walks
// the field extremes, every opcode and the corner cases of the frame table;
// random phases with different register settings and handshake pressure
// follow. A checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top;
    import pfa_pkg::*;

    localparam logic [MEM_W-1:0] MEM_MAX = '1;
    localparam int RANDOM_PER_PHASE = 52;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    req_word_t             req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_word_t             rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending_words;

    // Handshake pressure, in percent of cycles.
    int unsigned           send_idle_pct;
    int unsigned           rsp_stall_pct;
    // Page size last written, used to size allocate requests.
    logic [PS_W-1:0]       page_bytes;
    logic [PID_W-1:0]      pid_pool [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'h3C};

    paging_frame_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_table_checker #(.NUM_FRAMES(NUM_FRAMES_DEF)) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Response side back-pressure.
    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

    function automatic req_word_t mk_req(input opcode_t op, input logic [PID_W-1:0] pid,
                                         input logic [MEM_W-1:0] mem);
        req_word_t r;
        r.opcode     = op;
        r.process_id = pid;
        r.mem_bytes  = mem;
        return r;
    endfunction

    // Mostly small allocations from a few owners, so frees and lists hit.
    function automatic req_word_t random_request();
        req_word_t       r;
        int unsigned     roll;
        int unsigned     pages;
        int unsigned     unit;
        longint unsigned bytes;
        roll         = $urandom_range(99);
        r.process_id = ($urandom_range(99) < 80) ? pid_pool[$urandom_range(5)]
                                                 : PID_W'($urandom);
        r.mem_bytes  = MEM_W'($urandom);
        if (roll < 48)
        begin
            r.opcode = OP_ALLOC;
            unit     = (page_bytes == 0) ? 1 : page_bytes;
            pages    = ($urandom_range(9) == 0) ? $urandom_range(33, 9)
                                                : $urandom_range(8, 1);
            bytes    = longint'(pages - 1) * unit + $urandom_range(unit, 1);
            case ($urandom_range(19))
                0:       r.mem_bytes = '0;
                1:       r.mem_bytes = MEM_W'($urandom);
                default: r.mem_bytes = (bytes > MEM_MAX) ? MEM_MAX : MEM_W'(bytes);
            endcase
        end
        else if (roll < 68)
            r.opcode = OP_FREE;
        else if (roll < 86)
            r.opcode = OP_LIST_PROC;
        else
            r.opcode = OP_LIST_FREE;
        return r;
    endfunction

    // Offer one request word and return on the edge that accepts it.
    task automatic send_req(input req_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(negedge clk);
        while (!req_ready);
        @(posedge clk);
    endtask

    // Stop offering requests and wait until every expected word has come.
    task automatic wait_quiet();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_words != 0);
        @(posedge clk);
    endtask

    // Write both registers, the frame count first and then the page size.
    task automatic set_config(input logic [COUNT_W-1:0] frames, input logic [PS_W-1:0] bytes);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAMES_IN_USE;
        cfg_data  <= CFG_DATA_W'(frames);
        @(posedge clk);
        cfg_index <= CFG_PAGE_SIZE;
        cfg_data  <= bytes;
        page_bytes = bytes;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Safety net against a hung handshake.
    initial
    begin
        #8000000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        req_valid     <= 1'b0;
        req           <= '0;
        rsp_ready     <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_FRAMES_IN_USE;
        cfg_data      <= '0;
        send_idle_pct  = 0;
        rsp_stall_pct  = 0;
        page_bytes     = PAGE_SIZE_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full table, 4 KiB pages.
        send_req(mk_req(OP_LIST_FREE, 8'h00, '0));
        send_req(mk_req(OP_ALLOC, 8'h00, 22'd0));
        send_req(mk_req(OP_ALLOC, 8'h00, 22'd1));
        send_req(mk_req(OP_ALLOC, 8'hFF, 22'd12288));
        send_req(mk_req(OP_ALLOC, 8'hAA, 22'd4097));
        send_req(mk_req(OP_ALLOC, 8'h55, MEM_MAX));
        send_req(mk_req(OP_LIST_PROC, 8'hFF, MEM_MAX));
        send_req(mk_req(OP_LIST_PROC, 8'h12, '0));
        send_req(mk_req(OP_LIST_FREE, 8'hFF, '0));
        send_req(mk_req(OP_FREE, 8'hAA, '0));
        send_req(mk_req(OP_FREE, 8'h77, '0));
        // Fill the table exactly, then ask once more.
        send_req(mk_req(OP_ALLOC, 8'h33, 22'd114688));
        send_req(mk_req(OP_ALLOC, 8'h44, 22'd1));
        send_req(mk_req(OP_LIST_FREE, 8'h00, '0));
        send_req(mk_req(OP_LIST_PROC, 8'h33, '0));

        // No active frames: nothing is scanned or changed.
        wait_quiet();
        set_config(6'd0, 16'hFFFF);
        send_req(mk_req(OP_ALLOC, 8'h01, 22'd1));
        send_req(mk_req(OP_LIST_FREE, 8'h00, '0));
        send_req(mk_req(OP_FREE, 8'h33, '0));

        // One active frame and a zero page size.
        wait_quiet();
        set_config(6'd1, 16'd0);
        send_req(mk_req(OP_LIST_PROC, 8'h00, '0));
        send_req(mk_req(OP_FREE, 8'h00, '0));
        send_req(mk_req(OP_ALLOC, 8'h80, 22'd1));
        send_req(mk_req(OP_ALLOC, 8'h80, 22'd2));

        // Frame count above the table size, largest page size.
        wait_quiet();
        set_config(6'd63, 16'hFFFF);
        send_req(mk_req(OP_ALLOC, 8'h01, MEM_MAX));
        send_req(mk_req(OP_FREE, 8'h33, '0));
        send_req(mk_req(OP_FREE, 8'hFF, '0));
        send_req(mk_req(OP_ALLOC, 8'h7F, 22'd2031585));

        // Random phases, each with its own settings and handshake pressure.
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_quiet();
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                    set_config(6'd63, 16'd1);
                end
                1:
                begin
                    send_idle_pct = 82;
                    rsp_stall_pct = 0;
                    set_config(COUNT_W'($urandom_range(31, 2)), PS_W'($urandom_range(65535, 1)));
                end
                2:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 82;
                    set_config(6'd32, 16'd0);
                end
                default:
                begin
                    send_idle_pct = 32;
                    rsp_stall_pct = 32;
                    set_config(COUNT_W'($urandom_range(63, 1)), PS_W'($urandom_range(8192, 1)));
                end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_req(random_request());
        end

        // Drain, then leave room for any stray word.
        wait_quiet();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
